[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They are compiled out when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequence violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/blpg_pkg.sv]
// ---------------------------------------------------------------------------
// Line pixel generator package
// Command codes and fixed field widths of the line pixel generator.
// ---------------------------------------------------------------------------
package blpg_pkg;

  localparam int MODE_BITS  = 3;
  localparam int COLOR_BITS = 8;

  // Command carried with each input transfer.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_MOVE_TO  = 3'd0,
    MODE_LINE_TO  = 3'd1,
    MODE_MOVE_REL = 3'd2,
    MODE_LINE_REL = 3'd3,
    MODE_STEP     = 3'd4
  } mode_t;

endpackage

[hw/rtl/bresenham_line_pixel_generator_core.sv]
// ---------------------------------------------------------------------------
// Bresenham line pixel generator core
// A pen-based line drawer that turns move, line and step commands into
// pixel coordinates. Move commands (absolute, or relative with wrap-around
// modulo the coordinate range) reposition the pen and give no pixel. Line
// commands set up a Bresenham walk from the pen to the target, emit the
// first pixel straight away and leave the pen at the target; every step
// command then emits the next pixel, with tlast marking the final one. A
// step with no line in progress gives nothing, and a move or line command
// abandons an unfinished line. Each pixel carries the draw colour held in
// the configuration register at the time the command is taken. The core
// takes one command per clock cycle: every command is resolved by the
// combinational setup and error-update logic in front of the pen and walk
// registers, and its pixel goes to the output register, or to the skid
// entry while the output stalls. A two-entry output buffer lets one more
// pixel in while another waits on a stalled receiver; in_tready drops only
// when both entries are full. Commands above the step code are ignored.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bresenham_line_pixel_generator_core #(
  parameter int COORD_BITS = 9,
  localparam int IN_BITS   = 4 * COORD_BITS + 2,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 2 * COORD_BITS + blpg_pkg::COLOR_BITS,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration: draw colour.
  input  logic                              cfg_wr_en,
  input  logic [blpg_pkg::COLOR_BITS-1:0]   cfg_wr_data,
  // Command stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, from bit 0: pos_x, pos_y, delta_x, delta_y, zero padding.
  input  logic [IN_W-1:0]                   in_tdata,
  // tuser: mode.
  input  logic [blpg_pkg::MODE_BITS-1:0]    in_tuser,
  // Pixel stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata, from bit 0: pixel_x, pixel_y, pixel_color, zero padding.
  output logic [OUT_W-1:0]                  out_tdata,
  // tlast: line_last.
  output logic                              out_tlast
);

  localparam int C = COORD_BITS;
  localparam logic [C-1:0] COORD_ONE = C'(1);

  typedef struct packed {
    logic [C-1:0]                    x;
    logic [C-1:0]                    y;
    logic [blpg_pkg::COLOR_BITS-1:0] color;
    logic                            last;
  } pixel_t;

  // Configuration register.
  logic [blpg_pkg::COLOR_BITS-1:0] draw_color_r;

  // Pen and walk state.
  logic [C-1:0]        pen_x_r, pen_x_nxt;
  logic [C-1:0]        pen_y_r, pen_y_nxt;
  logic                line_active_r, line_active_nxt;
  logic                axes_swapped_r, axes_swapped_nxt;
  logic [C-1:0]        major_pos_r, major_pos_nxt;
  logic [C-1:0]        major_end_r, major_end_nxt;
  logic [C-1:0]        minor_pos_r, minor_pos_nxt;
  logic                minor_descends_r, minor_descends_nxt;
  logic [C-1:0]        major_span_r, major_span_nxt;
  logic [C-1:0]        minor_span_r, minor_span_nxt;
  logic signed [C+1:0] error_acc_r, error_acc_nxt;

  // Output register and skid entry.
  logic   out_valid_r, skid_valid_r;
  pixel_t out_pix_r, skid_pix_r;

  // Input fields.
  blpg_pkg::mode_t mode;
  logic [C-1:0]    pos_x, pos_y;
  logic [C:0]      delta_x, delta_y;
  logic            in_acc;

  assign mode    = blpg_pkg::mode_t'(in_tuser);
  assign pos_x   = in_tdata[C-1:0];
  assign pos_y   = in_tdata[2*C-1:C];
  assign delta_x = in_tdata[3*C:2*C];
  assign delta_y = in_tdata[4*C+1:3*C+1];

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  // Target of the command: relative targets wrap modulo the coordinate range.
  logic         is_rel;
  logic [C-1:0] tgt_x, tgt_y;

  assign is_rel = (mode == blpg_pkg::MODE_MOVE_REL) || (mode == blpg_pkg::MODE_LINE_REL);
  assign tgt_x  = is_rel ? (pen_x_r + delta_x[C-1:0]) : pos_x;
  assign tgt_y  = is_rel ? (pen_y_r + delta_y[C-1:0]) : pos_y;

  // Line setup: pick the major axis and order the endpoints so that it ascends.
  logic [C-1:0] dx, dy, a0, a1, b0, b1;
  logic [C-1:0] s_maj0, s_maj1, s_min0, s_min1;
  logic         s_swap, s_flip;

  always_comb begin
    dx     = (tgt_x > pen_x_r) ? (tgt_x - pen_x_r) : (pen_x_r - tgt_x);
    dy     = (tgt_y > pen_y_r) ? (tgt_y - pen_y_r) : (pen_y_r - tgt_y);
    s_swap = dy > dx;
    a0     = s_swap ? pen_y_r : pen_x_r;
    b0     = s_swap ? pen_x_r : pen_y_r;
    a1     = s_swap ? tgt_y : tgt_x;
    b1     = s_swap ? tgt_x : tgt_y;
    s_flip = a0 > a1;
    s_maj0 = s_flip ? a1 : a0;
    s_maj1 = s_flip ? a0 : a1;
    s_min0 = s_flip ? b1 : b0;
    s_min1 = s_flip ? b0 : b1;
  end

  // Walk values for this command: a fresh setup for a line, the stored
  // walk for a step.
  logic                is_line;
  logic                cur_swap, cur_desc;
  logic [C-1:0]        cur_maj, cur_end, cur_min, cur_majspan, cur_minspan;
  logic signed [C+1:0] cur_err;

  assign is_line = (mode == blpg_pkg::MODE_LINE_TO) || (mode == blpg_pkg::MODE_LINE_REL);

  always_comb begin
    if (is_line) begin
      cur_swap    = s_swap;
      cur_maj     = s_maj0;
      cur_end     = s_maj1;
      cur_min     = s_min0;
      cur_desc    = !(s_min0 < s_min1);
      cur_majspan = s_maj1 - s_maj0;
      cur_minspan = (s_min1 > s_min0) ? (s_min1 - s_min0) : (s_min0 - s_min1);
      cur_err     = '0;
    end else begin
      cur_swap    = axes_swapped_r;
      cur_maj     = major_pos_r;
      cur_end     = major_end_r;
      cur_min     = minor_pos_r;
      cur_desc    = minor_descends_r;
      cur_majspan = major_span_r;
      cur_minspan = minor_span_r;
      cur_err     = error_acc_r;
    end
  end

  // Pixel for this command and the Bresenham advance to the next one.
  pixel_t              pix;
  logic signed [C+1:0] err_sum, adv_err;
  logic signed [C+2:0] err_twice, span_ext;
  logic                minor_move;
  logic [C-1:0]        adv_min, adv_maj;

  always_comb begin
    pix.x      = cur_swap ? cur_min : cur_maj;
    pix.y      = cur_swap ? cur_maj : cur_min;
    pix.color  = draw_color_r;
    pix.last   = (cur_maj == cur_end);
    err_sum    = cur_err + $signed({2'b00, cur_minspan});
    err_twice  = $signed({err_sum, 1'b0});
    span_ext   = $signed({3'b000, cur_majspan});
    minor_move = err_twice >= span_ext;
    adv_err    = minor_move ? (err_sum - $signed({2'b00, cur_majspan})) : err_sum;
    adv_min    = minor_move ? (cur_desc ? (cur_min - COORD_ONE) : (cur_min + COORD_ONE))
                            : cur_min;
    adv_maj    = cur_maj + COORD_ONE;
  end

  // Command decode and next state.
  logic res_vld;

  always_comb begin
    pen_x_nxt          = pen_x_r;
    pen_y_nxt          = pen_y_r;
    line_active_nxt    = line_active_r;
    axes_swapped_nxt   = axes_swapped_r;
    major_pos_nxt      = major_pos_r;
    major_end_nxt      = major_end_r;
    minor_pos_nxt      = minor_pos_r;
    minor_descends_nxt = minor_descends_r;
    major_span_nxt     = major_span_r;
    minor_span_nxt     = minor_span_r;
    error_acc_nxt      = error_acc_r;
    res_vld            = 1'b0;
    unique case (mode) inside
      blpg_pkg::MODE_MOVE_TO, blpg_pkg::MODE_MOVE_REL: begin
        pen_x_nxt       = tgt_x;
        pen_y_nxt       = tgt_y;
        line_active_nxt = 1'b0;
      end
      blpg_pkg::MODE_LINE_TO, blpg_pkg::MODE_LINE_REL: begin
        res_vld            = in_acc;
        pen_x_nxt          = tgt_x;
        pen_y_nxt          = tgt_y;
        axes_swapped_nxt   = cur_swap;
        major_end_nxt      = cur_end;
        minor_descends_nxt = cur_desc;
        major_span_nxt     = cur_majspan;
        minor_span_nxt     = cur_minspan;
        line_active_nxt    = !pix.last;
        major_pos_nxt      = pix.last ? cur_maj : adv_maj;
        minor_pos_nxt      = pix.last ? cur_min : adv_min;
        error_acc_nxt      = pix.last ? cur_err : adv_err;
      end
      blpg_pkg::MODE_STEP: begin
        if (line_active_r) begin
          res_vld = in_acc;
          if (pix.last) begin
            line_active_nxt = 1'b0;
          end else begin
            major_pos_nxt = adv_maj;
            minor_pos_nxt = adv_min;
            error_acc_nxt = adv_err;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_color_r <= '0;
    end else if (cfg_wr_en) begin
      draw_color_r <= cfg_wr_data;
    end
  end

  // Pen and walk registers update only on an accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r          <= '0;
      pen_y_r          <= '0;
      line_active_r    <= 1'b0;
      axes_swapped_r   <= 1'b0;
      major_pos_r      <= '0;
      major_end_r      <= '0;
      minor_pos_r      <= '0;
      minor_descends_r <= 1'b0;
      major_span_r     <= '0;
      minor_span_r     <= '0;
      error_acc_r      <= '0;
    end else if (in_acc) begin
      pen_x_r          <= pen_x_nxt;
      pen_y_r          <= pen_y_nxt;
      line_active_r    <= line_active_nxt;
      axes_swapped_r   <= axes_swapped_nxt;
      major_pos_r      <= major_pos_nxt;
      major_end_r      <= major_end_nxt;
      minor_pos_r      <= minor_pos_nxt;
      minor_descends_r <= minor_descends_nxt;
      major_span_r     <= major_span_nxt;
      minor_span_r     <= minor_span_nxt;
      error_acc_r      <= error_acc_nxt;
    end
  end

  // Output register with one skid entry. A new pixel can only arrive while
  // the skid entry is empty, because in_tready is low otherwise.
  logic out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_vld;
      end
    end else if (res_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_pix_r <= skid_valid_r ? skid_pix_r : pix;
    end
    if (!out_free && res_vld) begin
      skid_pix_r <= pix;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_pix_r.color, out_pix_r.y, out_pix_r.x});
  assign out_tlast  = out_pix_r.last;

  // The skid entry is only ever filled behind a waiting output register.
  `ASSERT_ALWAYS(a_skid_behind_out, clk, rst_n, !skid_valid_r || out_valid_r)
  // A pixel produced against a stalled output must be parked in the skid entry.
  `ASSERT_NEXT(a_stall_parks_pixel, clk, rst_n, res_vld && out_valid_r && !out_tready, skid_valid_r)
  // Emitting the final pixel of a line leaves no line in progress.
  `ASSERT_NEXT(a_last_ends_line, clk, rst_n, res_vld && pix.last, !line_active_r)
  // A step with no line in progress produces no pixel.
  `ASSERT_ALWAYS(a_idle_step, clk, rst_n, !res_vld || mode != blpg_pkg::MODE_STEP || line_active_r)

endmodule

[tb/blpg_pixel_checker.sv]
// ---------------------------------------------------------------------------
// Pixel stream checker for the line pixel generator
// Watches the command, colour and pixel channels of the core. It keeps its
// own model of the pen and of the Bresenham walk, and compares every pixel
// transfer with the oldest predicted pixel.
// ---------------------------------------------------------------------------
module blpg_pixel_checker #(
  parameter int COORD_BITS = 9,
  localparam int IN_W      = ((4 * COORD_BITS + 2 + 7) / 8) * 8,
  localparam int OUT_W     = ((2 * COORD_BITS + blpg_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [blpg_pkg::COLOR_BITS-1:0] cfg_wr_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,
  input  logic [blpg_pkg::MODE_BITS-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [OUT_W-1:0]                out_tdata,
  input  logic                            out_tlast,
  output int                              mismatch_count,
  output int                              pixels_waiting,
  output int                              pixels_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int C     = COORD_BITS;
  localparam int ERR_W = COORD_BITS + 2;

  typedef logic [C-1:0] coord_t;

  typedef struct packed {
    coord_t                            x;
    coord_t                            y;
    logic [blpg_pkg::COLOR_BITS-1:0]   color;
    logic                              last;
  } pixel_t;

  // Predicted state of the core.
  logic [blpg_pkg::COLOR_BITS-1:0] ink;
  coord_t                          cursor_x, cursor_y;
  logic                            walk_active, steep, rise_down;
  coord_t                          run_pos, run_end, rise_pos, run_len, rise_len;
  logic signed [ERR_W-1:0]         slope_err;
  pixel_t                          expected_pixels[$];

  initial begin
    mismatch_count = 0;
    pixels_checked = 0;
    pixels_waiting = 0;
  end

  function automatic coord_t gap_between(coord_t a, coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  task plot(input logic at_end);
    pixel_t p;
    p.x     = steep ? rise_pos : run_pos;
    p.y     = steep ? run_pos : rise_pos;
    p.color = ink;
    p.last  = at_end;
    expected_pixels.push_back(p);
  endtask

  task walk_advance();
    slope_err = slope_err + ERR_W'(rise_len);
    if (2 * int'(slope_err) >= int'(run_len)) begin
      rise_pos  = rise_down ? rise_pos - 1'b1 : rise_pos + 1'b1;
      slope_err = slope_err - ERR_W'(run_len);
    end
    run_pos = run_pos + 1'b1;
  endtask

  task begin_line(input coord_t tx, input coord_t ty);
    coord_t ax, ay, bx, by, t;
    logic   at_end;
    ax = cursor_x;
    ay = cursor_y;
    bx = tx;
    by = ty;
    steep = gap_between(by, ay) > gap_between(bx, ax);
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    run_pos   = ax;
    run_end   = bx;
    rise_pos  = ay;
    run_len   = bx - ax;
    rise_len  = gap_between(by, ay);
    rise_down = !(ay < by);
    slope_err = '0;
    cursor_x  = tx;
    cursor_y  = ty;
    at_end    = (run_pos == run_end);
    plot(at_end);
    walk_active = !at_end;
    if (!at_end) walk_advance();
  endtask

  always @(posedge clk) begin : watch
    pixel_t want, got;
    coord_t rel_x, rel_y;
    logic   at_end;
    if (!rst_n) begin
      ink         = '0;
      cursor_x    = '0;
      cursor_y    = '0;
      walk_active = 1'b0;
      steep       = 1'b0;
      rise_down   = 1'b0;
      run_pos     = '0;
      run_end     = '0;
      rise_pos    = '0;
      run_len     = '0;
      rise_len    = '0;
      slope_err   = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) ink = cfg_wr_data;

      // A result is registered in the core before it leaves, so the pixel
      // transfer is retired before this edge's command is predicted.
      if (out_tvalid && out_tready) begin
        got.x     = out_tdata[C-1:0];
        got.y     = out_tdata[2*C-1:C];
        got.color = out_tdata[2*C+blpg_pkg::COLOR_BITS-1:2*C];
        got.last  = out_tlast;
        if (expected_pixels.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected pixel x=%0d y=%0d colour=%0d last=%0b",
                     $realtime, got.x, got.y, got.color, got.last);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (want !== got) begin
            if (mismatch_count < 10)
              $display({"%0t: pixel mismatch, expected x=%0d y=%0d colour=%0d last=%0b,",
                        " got x=%0d y=%0d colour=%0d last=%0b"},
                       $realtime, want.x, want.y, want.color, want.last,
                       got.x, got.y, got.color, got.last);
            mismatch_count++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        rel_x = cursor_x + in_tdata[3*C-1:2*C];
        rel_y = cursor_y + in_tdata[4*C:3*C+1];
        case (in_tuser)
          blpg_pkg::MODE_MOVE_TO: begin
            walk_active = 1'b0;
            cursor_x    = in_tdata[C-1:0];
            cursor_y    = in_tdata[2*C-1:C];
          end
          blpg_pkg::MODE_LINE_TO: begin
            begin_line(in_tdata[C-1:0], in_tdata[2*C-1:C]);
          end
          blpg_pkg::MODE_MOVE_REL: begin
            walk_active = 1'b0;
            cursor_x    = rel_x;
            cursor_y    = rel_y;
          end
          blpg_pkg::MODE_LINE_REL: begin
            begin_line(rel_x, rel_y);
          end
          blpg_pkg::MODE_STEP: begin
            if (walk_active) begin
              at_end = (run_pos == run_end);
              plot(at_end);
              if (at_end) walk_active = 1'b0;
              else walk_advance();
            end
          end
          default: begin
            // Spare codes leave the pen and any walk untouched.
          end
        endcase
      end
    end
    pixels_waiting <= expected_pixels.size();
  end

endmodule

[tb/tb_bresenham_line_pixel_generator_core.sv]
// ---------------------------------------------------------------------------
// Line pixel generator core testbench
// Drives move, line and step commands into the core and lets a checker
// compare every pixel transfer with its own prediction. A short directed
// sequence covers the field extremes and the corner cases; randomised
// strokes under several draw colours follow, with bursty input and a
// stalling pixel receiver.
// ---------------------------------------------------------------------------
module tb_bresenham_line_pixel_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MODE_BITS    = blpg_pkg::MODE_BITS;
  localparam int COLOR_BITS   = blpg_pkg::COLOR_BITS;
  localparam int COORD_BITS   = 9;
  localparam int DELTA_BITS   = COORD_BITS + 1;
  localparam int IN_W         = ((4 * COORD_BITS + 2 + 7) / 8) * 8;
  localparam int OUT_W        = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 500;

  // Command codes above the step code, which the core must ignore.
  localparam logic [MODE_BITS-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_7 = 3'd7;

  // How the pixel receiver paces its tready.
  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PERIODIC
  } ready_style_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [COLOR_BITS-1:0]  cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // tdata, from bit 0: pos_x, pos_y, delta_x, delta_y, zero padding.
  logic [IN_W-1:0]        in_tdata = '0;
  // tuser: mode.
  logic [MODE_BITS-1:0]   in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // tdata, from bit 0: pixel_x, pixel_y, pixel_color, zero padding.
  logic [OUT_W-1:0]       out_tdata;
  // tlast: line_last.
  logic                   out_tlast;

  int mismatch_count;
  int pixels_waiting;
  int pixels_checked;

  int commands_sent   = 0;
  int colour_settings = 0;
  int burst_left      = 1;

  ready_style_t ready_style = READY_ALWAYS;
  int           style_timer = 0;
  int           tick        = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bresenham_line_pixel_generator_core #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  blpg_pixel_checker #(
    .COORD_BITS(COORD_BITS)
  ) pixel_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .pixels_waiting(pixels_waiting),
    .pixels_checked(pixels_checked)
  );

  // The pixel receiver switches between pacing styles at random intervals,
  // so stalls land on every phase of a walk, including long runs with
  // tready held high.
  always @(posedge clk) begin
    tick <= tick + 1;
    if (style_timer == 0) begin
      ready_style <= ready_style_t'($urandom_range(0, 3));
      style_timer <= $urandom_range(20, 150);
    end else begin
      style_timer <= style_timer - 1;
    end
    case (ready_style)
      READY_ALWAYS:  out_tready <= 1'b1;
      READY_MOSTLY:  out_tready <= ($urandom_range(0, 3) != 0);
      READY_RARELY:  out_tready <= ($urandom_range(0, 3) == 0);
      default:       out_tready <= ((tick % 5) < 2);
    endcase
  end

  // Presents one command and holds it until the core takes the transfer.
  // Commands go out in bursts; at the end of a burst tvalid drops before
  // the next command is offered.
  task automatic send_cmd(input logic [MODE_BITS-1:0] mode, input int px, input int py,
                          input int dx, input int dy);
    in_tuser  <= mode;
    in_tdata  <= IN_W'({DELTA_BITS'(dy), DELTA_BITS'(dx), COORD_BITS'(py), COORD_BITS'(px)});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    commands_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 30);
    end
  endtask

  // Holds the input off until every predicted pixel has left the core, then
  // gives a move or an ignored command time to settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pixels_waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_ink(input logic [COLOR_BITS-1:0] colour);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= colour;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    colour_settings++;
  endtask

  function automatic int any_coord();
    return $urandom_range(0, COORD_MAX);
  endfunction

  // Coordinates that often sit at the edges, so relative commands wrap.
  function automatic int edge_coord();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(COORD_MAX - 3, COORD_MAX);
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  function automatic int any_delta();
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  function automatic int short_delta();
    return int'($urandom_range(0, 32)) - 16;
  endfunction

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Steps through a line; now and then the walk is cut short or overrun
  // so that abandoned lines and idle steps appear too.
  task automatic walk(input int span);
    int steps;
    steps = ($urandom_range(0, 9) < 7) ? span : int'($urandom_range(0, span + 3));
    repeat (steps)
      send_cmd(blpg_pkg::MODE_STEP, any_coord(), any_coord(), any_delta(), any_delta());
  endtask

  // One random stroke: mostly a line with its steps, sometimes a bare
  // move or a command with random code and fields.
  task automatic draw_stroke();
    int kind, x0, y0, dx, dy;
    kind = $urandom_range(0, 99);
    dx   = short_delta();
    dy   = short_delta();
    if (kind < 10) begin
      send_cmd(MODE_BITS'($urandom_range(0, 7)), any_coord(), any_coord(),
               any_delta(), any_delta());
    end else if (kind < 18) begin
      send_cmd(blpg_pkg::MODE_MOVE_TO, edge_coord(), edge_coord(), any_delta(), any_delta());
    end else if (kind < 24) begin
      send_cmd(blpg_pkg::MODE_MOVE_REL, any_coord(), any_coord(), any_delta(), any_delta());
    end else if (kind < 65) begin
      send_cmd(blpg_pkg::MODE_LINE_REL, any_coord(), any_coord(), dx, dy);
      walk(magnitude(dx) > magnitude(dy) ? magnitude(dx) : magnitude(dy));
    end else if (kind < 85) begin
      // A move and an absolute line close by, so the walk can be finished.
      x0 = edge_coord();
      y0 = edge_coord();
      send_cmd(blpg_pkg::MODE_MOVE_TO, x0, y0, any_delta(), any_delta());
      send_cmd(blpg_pkg::MODE_LINE_TO, (x0 + dx) & COORD_MAX, (y0 + dy) & COORD_MAX,
               any_delta(), any_delta());
      walk(magnitude(dx) > magnitude(dy) ? magnitude(dx) : magnitude(dy));
    end else begin
      // Long lines anywhere; these are mostly abandoned part way.
      if (kind < 93)
        send_cmd(blpg_pkg::MODE_LINE_TO, any_coord(), any_coord(), any_delta(), any_delta());
      else
        send_cmd(blpg_pkg::MODE_LINE_REL, any_coord(), any_coord(), any_delta(), any_delta());
      walk($urandom_range(0, 12));
    end
  endtask

  initial begin
    logic [COLOR_BITS-1:0] phase_ink[5];
    int                    phase_end;
    burst_left = $urandom_range(1, 30);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A zero-length line at the reset pen gives one pixel
    // flagged last in the reset colour, and a step after it gives nothing.
    send_cmd(blpg_pkg::MODE_LINE_TO, 0, 0, 0, 0);
    send_cmd(blpg_pkg::MODE_STEP, 0, 0, 0, 0);
    wait_drained();
    set_ink(8'hFF);

    // A full diagonal from the far corner, cut off by a relative move that
    // wraps on the x axis.
    send_cmd(blpg_pkg::MODE_MOVE_TO, COORD_MAX, COORD_MAX, 0, 0);
    send_cmd(blpg_pkg::MODE_LINE_TO, 0, 0, 511, -512);
    send_cmd(blpg_pkg::MODE_STEP, COORD_MAX, 0, -512, 511);
    send_cmd(blpg_pkg::MODE_STEP, 0, COORD_MAX, 511, -512);
    send_cmd(blpg_pkg::MODE_MOVE_REL, 0, 0, -512, 511);

    // A shallow line with a falling minor axis; spare codes in the middle
    // must not disturb it, and the colour changes before its last pixel.
    send_cmd(blpg_pkg::MODE_LINE_REL, COORD_MAX, COORD_MAX, 3, -1);
    send_cmd(MODE_SPARE_5, 0, 0, 0, 0);
    send_cmd(blpg_pkg::MODE_STEP, 0, 0, 0, 0);
    send_cmd(MODE_SPARE_7, COORD_MAX, COORD_MAX, 511, 511);
    send_cmd(blpg_pkg::MODE_STEP, 0, 0, 0, 0);
    wait_drained();
    set_ink(8'h5A);
    send_cmd(blpg_pkg::MODE_STEP, 0, 0, 0, 0);
    send_cmd(blpg_pkg::MODE_STEP, 0, 0, 0, 0);

    // A steep line walked along y with x falling, taken to its end.
    send_cmd(blpg_pkg::MODE_MOVE_TO, 5, 2, 0, 0);
    send_cmd(blpg_pkg::MODE_LINE_TO, 3, 7, 0, 0);
    repeat (5) send_cmd(blpg_pkg::MODE_STEP, 0, 0, 0, 0);
    send_cmd(MODE_SPARE_6, 0, 0, 0, 0);
    send_cmd(blpg_pkg::MODE_LINE_REL, 0, 0, -2, -2);
    send_cmd(blpg_pkg::MODE_STEP, 0, 0, 0, 0);
    wait_drained();

    // Random strokes in phases, each under its own draw colour and each
    // ending with the input held off until all pixels have drained.
    phase_ink[0] = 8'h00;
    phase_ink[1] = COLOR_BITS'($urandom_range(0, 255));
    phase_ink[2] = 8'hFF;
    phase_ink[3] = COLOR_BITS'($urandom_range(0, 255));
    phase_ink[4] = 8'h80;
    phase_end    = commands_sent;
    foreach (phase_ink[p]) begin
      set_ink(phase_ink[p]);
      phase_end += RANDOM_ITEMS / 5;
      while (commands_sent < phase_end) begin
        draw_stroke();
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
      wait_drained();
    end

    $display("Run covered %0d commands under %0d draw colours; %0d pixels compared.",
             commands_sent, colour_settings, pixels_checked);
    if (mismatch_count == 0 && pixels_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #3_000_000;
    $display("Timed out with %0d pixels outstanding.", pixels_waiting);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/blpg_pkg.sv
hw/rtl/bresenham_line_pixel_generator_core.sv
tb/blpg_pixel_checker.sv
tb/tb_bresenham_line_pixel_generator_core.sv
